// ===== hdl/hpi_pkg.sv =====
package hpi_pkg;

  // Field widths
  localparam int TEMP_W = 10;
  localparam int POT_W  = 12;
  localparam int REF_W  = 8;
  localparam int DUTY_W = 16;
  localparam int LED_W  = 2;
  localparam int ERR_W  = 12;
  localparam int PEAK_W = 10;

  // Fixed-point format of the PI law
  localparam int ACC_WIDTH      = 48;
  localparam int COEF_FRAC_BITS = 24;

  localparam longint K1_VAL =
    (64'd1331353 * (64'd1 << COEF_FRAC_BITS) + 64'd5000000) / 64'd10000000;
  localparam longint K2_VAL =
    (64'd1327 * (64'd1 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam longint FULL_SCALE =
    (64'd359465 * (64'd1 << (COEF_FRAC_BITS + 2)) + 64'd50000) / 64'd100000;

  // Both gains stay below 2^(F-2), so the weighted error sum fits F+ERR_W signed bits
  localparam int PROD_W = COEF_FRAC_BITS + ERR_W;
  localparam int D_W    = $clog2(FULL_SCALE + 1);
  localparam int REM_W  = D_W + 2;
  localparam int CNT_W  = $clog2(DUTY_W);

  localparam logic signed [PROD_W-1:0] K1_P = PROD_W'(K1_VAL);
  localparam logic signed [PROD_W-1:0] K2_P = PROD_W'(K2_VAL);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_TOP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POT_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POT_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_LOW   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_MID   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_HIGH  = 3'd6;

  // Item kinds and control modes
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_BUTTON = 1'b1;
  localparam logic MODE_ONOFF  = 1'b0;
  localparam logic MODE_PI     = 1'b1;

  // LED codes
  localparam logic [LED_W-1:0] REF_LED_NONE = 2'd0;
  localparam logic [LED_W-1:0] REF_LED_LOW  = 2'd1;
  localparam logic [LED_W-1:0] REF_LED_MID  = 2'd2;
  localparam logic [LED_W-1:0] REF_LED_HIGH = 2'd3;
  localparam logic [LED_W-1:0] OV_LED_NONE  = 2'd0;
  localparam logic [LED_W-1:0] OV_LED_SMALL = 2'd1;
  localparam logic [LED_W-1:0] OV_LED_MID   = 2'd2;
  localparam logic [LED_W-1:0] OV_LED_BIG   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PI,
    ST_TRACK
  } ctl_state_t;

  typedef enum logic [2:0] {
    PU_IDLE,
    PU_MUL,
    PU_ACC,
    PU_CHK,
    PU_DIV,
    PU_DONE
  } pu_state_t;

  typedef struct packed {
    logic                    start;
    logic signed [ERR_W-1:0] err;
    logic [DUTY_W-1:0]       top;
  } pi_req_t;

  typedef struct packed {
    logic              done;
    logic              heater;
    logic [DUTY_W-1:0] duty;
  } pi_rsp_t;

endpackage

// ===== hdl/hpi_pi_unit.sv =====
module hpi_pi_unit
  import hpi_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  pi_req_t req,
  output pi_rsp_t rsp
);

  pu_state_t state_r, state_nxt;

  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [ERR_W-1:0]            e_sh_r, e_sh_nxt;
  logic [ERR_W-1:0]            ep_sh_r, ep_sh_nxt;
  logic signed [PROD_W-1:0]    prod_r, prod_nxt;
  logic signed [ACC_WIDTH-1:0] acc_r, acc_nxt;
  logic signed [ERR_W-1:0]     perr_r, perr_nxt;
  logic [D_W-1:0]              a_r, a_nxt;
  logic [D_W-1:0]              rem_r, rem_nxt;
  logic [DUTY_W-1:0]           q_r, q_nxt;
  logic [DUTY_W-1:0]           t_sh_r, t_sh_nxt;
  logic [DUTY_W-1:0]           duty_r, duty_nxt;
  logic                        heater_r, heater_nxt;

  localparam logic [REM_W-1:0] D1_P = REM_W'(FULL_SCALE);
  localparam logic [REM_W-1:0] D2_P = REM_W'(FULL_SCALE * 2);

  logic                        msb_step;
  logic signed [PROD_W-1:0]    add1, add2;
  logic signed [ACC_WIDTH:0]   acc_sum;
  logic [REM_W-1:0]            part, part_sub;
  logic [1:0]                  qdig;
  logic                        cnt_last;

  assign cnt_last = (cnt_r == '0);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      PU_IDLE: if (req.start) state_nxt = PU_MUL;
      PU_MUL:  if (cnt_last) state_nxt = PU_ACC;
      PU_ACC:  state_nxt = PU_CHK;
      PU_CHK: begin
        if (acc_r[ACC_WIDTH-1] || (acc_r >= ACC_WIDTH'(FULL_SCALE))) begin
          state_nxt = PU_DONE;
        end else begin
          state_nxt = PU_DIV;
        end
      end
      PU_DIV:  if (cnt_last) state_nxt = PU_DONE;
      PU_DONE: state_nxt = PU_IDLE;
      default: state_nxt = PU_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    rsp.done   = (state_r == PU_DONE);
    rsp.heater = heater_r;
    rsp.duty   = duty_r;
  end

  // Serial product step: one bit of each error per cycle, MSB first,
  // the sign bit carrying negative weight
  always_comb begin
    msb_step = (cnt_r == CNT_W'(ERR_W - 1));
    add1 = '0;
    add2 = '0;
    if (e_sh_r[ERR_W-1]) add1 = msb_step ? -K1_P : K1_P;
    if (ep_sh_r[ERR_W-1]) add2 = msb_step ? K2_P : -K2_P;
  end

  assign acc_sum = {acc_r[ACC_WIDTH-1], acc_r}
                 + {{(ACC_WIDTH + 1 - PROD_W){prod_r[PROD_W-1]}}, prod_r};

  // Division step: accumulate one bit of pwm_top times acc, reduce modulo D
  always_comb begin
    part = {1'b0, rem_r, 1'b0} + (t_sh_r[DUTY_W-1] ? {2'b00, a_r} : REM_W'(0));
    if (part >= D2_P) begin
      part_sub = part - D2_P;
      qdig     = 2'd2;
    end else if (part >= D1_P) begin
      part_sub = part - D1_P;
      qdig     = 2'd1;
    end else begin
      part_sub = part;
      qdig     = 2'd0;
    end
  end

  // Datapath
  always_comb begin
    cnt_nxt    = cnt_r;
    e_sh_nxt   = e_sh_r;
    ep_sh_nxt  = ep_sh_r;
    prod_nxt   = prod_r;
    acc_nxt    = acc_r;
    perr_nxt   = perr_r;
    a_nxt      = a_r;
    rem_nxt    = rem_r;
    q_nxt      = q_r;
    t_sh_nxt   = t_sh_r;
    duty_nxt   = duty_r;
    heater_nxt = heater_r;
    case (state_r)
      PU_IDLE: begin
        if (req.start) begin
          e_sh_nxt  = req.err;
          ep_sh_nxt = perr_r;
          perr_nxt  = req.err;
          prod_nxt  = '0;
          t_sh_nxt  = req.top;
          cnt_nxt   = CNT_W'(ERR_W - 1);
        end
      end
      PU_MUL: begin
        prod_nxt  = (prod_r <<< 1) + add1 + add2;
        e_sh_nxt  = e_sh_r << 1;
        ep_sh_nxt = ep_sh_r << 1;
        cnt_nxt   = cnt_r - 1'b1;
      end
      PU_ACC: begin
        // saturate on signed overflow
        if (acc_sum[ACC_WIDTH] != acc_sum[ACC_WIDTH-1]) begin
          acc_nxt = acc_sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                       : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end else begin
          acc_nxt = acc_sum[ACC_WIDTH-1:0];
        end
      end
      PU_CHK: begin
        if (acc_r[ACC_WIDTH-1]) begin
          duty_nxt   = '0;
          heater_nxt = 1'b0;
        end else begin
          heater_nxt = 1'b1;
          duty_nxt   = t_sh_r;
          a_nxt      = acc_r[D_W-1:0];
          rem_nxt    = '0;
          q_nxt      = '0;
          cnt_nxt    = CNT_W'(DUTY_W - 1);
        end
      end
      PU_DIV: begin
        rem_nxt  = part_sub[D_W-1:0];
        q_nxt    = (q_r << 1) + DUTY_W'(qdig);
        t_sh_nxt = t_sh_r << 1;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_last) duty_nxt = q_nxt;
      end
      PU_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= PU_IDLE;
      acc_r    <= '0;
      perr_r   <= '0;
      duty_r   <= '0;
      heater_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      acc_r    <= acc_nxt;
      perr_r   <= perr_nxt;
      duty_r   <= duty_nxt;
      heater_r <= heater_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    e_sh_r  <= e_sh_nxt;
    ep_sh_r <= ep_sh_nxt;
    prod_r  <= prod_nxt;
    a_r     <= a_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    t_sh_r  <= t_sh_nxt;
  end

endmodule

// ===== hdl/heater_pi_onoff_controller.sv =====
// Button items and on/off samples go from acceptance straight to the result load;
// PI samples pass 12 product steps, accumulate, range check, 16 divide steps,
// hand-off and result load, and skip the divide steps when the range check
// settles the duty alone. No new item is taken until the last result is loaded;
// a held result stalls the input until it is taken.
// Reset (rst_n low at a clock edge): state, configuration and status registers return to their defaults.
module heater_pi_onoff_controller
  import hpi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // sample_code[9:0], pot_value[21:10], zero pad
  input  logic                  in_tuser,   // kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [39:0]           out_tdata,  // pwm_duty[15:0], heater_on[16], ref_led[18:17],
                                            // peak_grade[20:19], overshoot_peak[30:21],
                                            // reference[38:31], zero pad
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  ctl_state_t state_r, state_nxt;

  logic              mode_r;
  logic [DUTY_W-1:0] pwm_top_r;
  logic [POT_W-1:0]  pot_low_r, pot_high_r;
  logic [REF_W-1:0]  ref_low_r, ref_mid_r, ref_high_r;

  logic [REF_W-1:0]  ref_r, ref_nxt;
  logic [LED_W-1:0]  ref_led_r, ref_led_nxt;
  logic [TEMP_W-1:0] last_temp_r, last_temp_nxt;
  logic [PEAK_W-1:0] peak_r, peak_nxt;
  logic [DUTY_W-1:0] duty_r, duty_nxt;
  logic              heater_r, heater_nxt;
  logic              out_tvalid_r;
  logic [39:0]       out_data_r;

  logic              accept, out_free, load_out;
  logic [TEMP_W-1:0] in_code;
  logic [POT_W-1:0]  in_pot;
  logic [TEMP_W-1:0] ref4;
  logic [TEMP_W-1:0] excess;
  logic [PEAK_W-1:0] peak_trk;
  logic [14:0]       peak25, peak5;
  logic [REF_W:0]    ref2;
  logic [LED_W-1:0]  ov_grade;

  pi_req_t pi_req;
  pi_rsp_t pi_rsp;

  assign in_code  = in_tdata[TEMP_W-1:0];
  assign in_pot   = in_tdata[TEMP_W +: POT_W];
  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;
  assign ref4     = {ref_r, 2'b00};

  hpi_pi_unit u_pi (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (pi_req),
    .rsp   (pi_rsp)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser == KIND_SAMPLE && mode_r == MODE_PI) begin
            state_nxt = ST_PI;
          end else begin
            state_nxt = ST_TRACK;
          end
        end
      end
      ST_PI:    if (pi_rsp.done) state_nxt = ST_TRACK;
      ST_TRACK: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_tready    = (state_r == ST_IDLE);
    load_out     = (state_r == ST_TRACK) && out_free;
    pi_req.start = accept && (in_tuser == KIND_SAMPLE) && (mode_r == MODE_PI);
    pi_req.err   = ERR_W'({2'b00, ref4}) - ERR_W'({2'b00, in_code});
    pi_req.top   = pwm_top_r;
  end

  // Peak tracking and grading against 2% and 10% of the reference
  always_comb begin
    excess   = last_temp_r - ref4;
    peak_trk = peak_r;
    if (last_temp_r >= ref4 && excess > peak_r) peak_trk = excess;
    peak25 = ({5'b0, peak_trk} << 4) + ({5'b0, peak_trk} << 3) + {5'b0, peak_trk};
    peak5  = ({5'b0, peak_trk} << 2) + {5'b0, peak_trk};
    ref2   = {ref_r, 1'b0};
    if (peak_trk == '0) begin
      ov_grade = OV_LED_NONE;
    end else if (peak25 <= 15'(ref2)) begin
      ov_grade = OV_LED_SMALL;
    end else if (peak5 <= 15'(ref2)) begin
      ov_grade = OV_LED_MID;
    end else begin
      ov_grade = OV_LED_BIG;
    end
  end

  // Item state
  always_comb begin
    ref_nxt       = ref_r;
    ref_led_nxt   = ref_led_r;
    last_temp_nxt = last_temp_r;
    peak_nxt      = peak_r;
    duty_nxt      = duty_r;
    heater_nxt    = heater_r;
    if (accept) begin
      if (in_tuser == KIND_BUTTON) begin
        peak_nxt = '0;
        if (in_pot <= pot_low_r) begin
          ref_nxt     = ref_low_r;
          ref_led_nxt = REF_LED_LOW;
        end else if (in_pot <= pot_high_r) begin
          ref_nxt     = ref_mid_r;
          ref_led_nxt = REF_LED_MID;
        end else begin
          ref_nxt     = ref_high_r;
          ref_led_nxt = REF_LED_HIGH;
        end
      end else begin
        last_temp_nxt = in_code;
        if (mode_r == MODE_ONOFF) begin
          if (in_code < ref4) begin
            duty_nxt   = pwm_top_r;
            heater_nxt = 1'b1;
          end else begin
            duty_nxt   = '0;
            heater_nxt = 1'b0;
          end
        end
      end
    end
    if (state_r == ST_PI && pi_rsp.done) begin
      duty_nxt   = pi_rsp.duty;
      heater_nxt = pi_rsp.heater;
    end
    if (load_out) peak_nxt = peak_trk;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mode_r       <= MODE_ONOFF;
      pwm_top_r    <= 16'd35999;
      pot_low_r    <= 12'd1365;
      pot_high_r   <= 12'd2375;
      ref_low_r    <= 8'd30;
      ref_mid_r    <= 8'd40;
      ref_high_r   <= 8'd45;
      ref_r        <= 8'd33;
      ref_led_r    <= REF_LED_NONE;
      last_temp_r  <= '0;
      peak_r       <= '0;
      duty_r       <= '0;
      heater_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ref_r       <= ref_nxt;
      ref_led_r   <= ref_led_nxt;
      last_temp_r <= last_temp_nxt;
      peak_r      <= peak_nxt;
      duty_r      <= duty_nxt;
      heater_r    <= heater_nxt;
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:     mode_r     <= cfg_wdata[0];
          CFG_PWM_TOP:  pwm_top_r  <= cfg_wdata[DUTY_W-1:0];
          CFG_POT_LOW:  pot_low_r  <= cfg_wdata[POT_W-1:0];
          CFG_POT_HIGH: pot_high_r <= cfg_wdata[POT_W-1:0];
          CFG_REF_LOW:  ref_low_r  <= cfg_wdata[REF_W-1:0];
          CFG_REF_MID:  ref_mid_r  <= cfg_wdata[REF_W-1:0];
          CFG_REF_HIGH: ref_high_r <= cfg_wdata[REF_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {1'b0, ref_r, peak_trk, ov_grade, ref_led_r, heater_r, duty_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import hpi_pkg::*;

  localparam int     CYCLE_LIMIT = 1_000_000;
  localparam int     FRAC        = 24;
  localparam int     ACC_BITS    = 48;
  localparam longint GAIN_NOW    =
    longint'((64'd1331353 * (64'd1 << FRAC) + 64'd5000000) / 64'd10000000);
  localparam longint GAIN_PREV   =
    longint'((64'd1327 * (64'd1 << FRAC) + 64'd5000) / 64'd10000);
  localparam longint DUTY_SCALE  =
    longint'((64'd359465 * (64'd1 << (FRAC + 2)) + 64'd50000) / 64'd100000);
  localparam longint ACC_MAX     = longint'((64'd1 << (ACC_BITS - 1)) - 64'd1);
  localparam longint ACC_MIN     = -ACC_MAX - 1;

  typedef struct packed {
    logic [15:0] duty;
    logic        heater;
    logic [1:0]  ref_led;
    logic [1:0]  ov_led;
    logic [9:0]  peak;
    logic [7:0]  ref_deg;
  } status_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [23:0]           in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [39:0]           out_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // register copies
  logic        cfg_mode   = MODE_ONOFF;
  logic [15:0] cfg_top    = 16'd35999;
  logic [11:0] cfg_pot_lo = 12'd1365;
  logic [11:0] cfg_pot_hi = 12'd2375;
  logic [7:0]  cfg_ref_lo = 8'd30;
  logic [7:0]  cfg_ref_mid = 8'd40;
  logic [7:0]  cfg_ref_hi = 8'd45;

  // regulator state
  logic [7:0]  ref_deg_q   = 8'd33;
  logic [1:0]  ref_led_q   = REF_LED_NONE;
  logic [9:0]  last_temp_q = '0;
  logic [9:0]  peak_q      = '0;
  longint      pi_acc      = 0;
  int          err_prev    = 0;
  logic [15:0] duty_q      = '0;
  logic        heater_q    = 1'b0;

  status_t pending_status[$];
  status_t want_status;
  int      mismatches  = 0;
  int      cycle_count = 0;
  int      out_gap     = 0;
  bit      burst_mode  = 1'b0;

  heater_pi_onoff_controller i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int draw_gap();
    return burst_mode ? 0 : int'($urandom_range(0, 10));
  endfunction

  // Advance the regulator by one item and return the status it shows afterwards.
  function automatic status_t heater_step(logic kind, logic [9:0] code, logic [11:0] pot);
    status_t res;
    longint  delta;
    longint  acc;
    int      err;
    int      r4;
    if (kind == KIND_BUTTON) begin
      peak_q = '0;
      if (pot <= cfg_pot_lo) begin
        ref_deg_q = cfg_ref_lo;
        ref_led_q = REF_LED_LOW;
      end else if (pot <= cfg_pot_hi) begin
        ref_deg_q = cfg_ref_mid;
        ref_led_q = REF_LED_MID;
      end else begin
        ref_deg_q = cfg_ref_hi;
        ref_led_q = REF_LED_HIGH;
      end
    end else begin
      last_temp_q = code;
      if (cfg_mode == MODE_ONOFF) begin
        heater_q = int'(code) < 4 * int'(ref_deg_q);
        duty_q   = heater_q ? cfg_top : 16'd0;
      end else begin
        err   = 4 * int'(ref_deg_q) - int'(code);
        delta = GAIN_NOW * longint'(err) - GAIN_PREV * longint'(err_prev);
        acc   = pi_acc;
        if (delta > 0 && acc > ACC_MAX - delta) acc = ACC_MAX;
        else if (delta < 0 && acc < ACC_MIN - delta) acc = ACC_MIN;
        else acc = acc + delta;
        pi_acc   = acc;
        err_prev = err;
        if (acc < 0) begin
          duty_q   = '0;
          heater_q = 1'b0;
        end else begin
          heater_q = 1'b1;
          if (acc >= DUTY_SCALE) duty_q = cfg_top;
          else duty_q = 16'((acc * longint'(cfg_top)) / DUTY_SCALE);
        end
      end
    end
    r4 = 4 * int'(ref_deg_q);
    if (int'(last_temp_q) >= r4 && int'(last_temp_q) - r4 > int'(peak_q))
      peak_q = 10'(int'(last_temp_q) - r4);
    res.duty    = duty_q;
    res.heater  = heater_q;
    res.ref_led = ref_led_q;
    res.peak    = peak_q;
    res.ref_deg = ref_deg_q;
    if (peak_q == '0) res.ov_led = OV_LED_NONE;
    else if (100 * int'(peak_q) <= 2 * r4) res.ov_led = OV_LED_SMALL;
    else if (100 * int'(peak_q) <= 10 * r4) res.ov_led = OV_LED_MID;
    else res.ov_led = OV_LED_BIG;
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
  endtask

  // Leaves in_tvalid high after acceptance so that back-to-back items need no
  // second assignment in the same step; a next call that draws a gap, or wait_idle, drops it.
  task automatic send_item(logic kind, logic [9:0] code, logic [11:0] pot);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {2'b00, pot, code};
    do @(posedge clk); while (!in_tready);
    pending_status.push_back(heater_step(kind, code, pot));
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_MODE:     cfg_mode    = val[0];
      CFG_PWM_TOP:  cfg_top     = val;
      CFG_POT_LOW:  cfg_pot_lo  = val[11:0];
      CFG_POT_HIGH: cfg_pot_hi  = val[11:0];
      CFG_REF_LOW:  cfg_ref_lo  = val[7:0];
      CFG_REF_MID:  cfg_ref_mid = val[7:0];
      CFG_REF_HIGH: cfg_ref_hi  = val[7:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic mode, logic [15:0] top, logic [11:0] pot_lo,
                           logic [11:0] pot_hi, logic [7:0] r_lo, logic [7:0] r_mid,
                           logic [7:0] r_hi);
    wait_idle();
    write_reg(CFG_MODE, {15'd0, mode});
    write_reg(CFG_PWM_TOP, top);
    write_reg(CFG_POT_LOW, {4'd0, pot_lo});
    write_reg(CFG_POT_HIGH, {4'd0, pot_hi});
    write_reg(CFG_REF_LOW, {8'd0, r_lo});
    write_reg(CFG_REF_MID, {8'd0, r_mid});
    write_reg(CFG_REF_HIGH, {8'd0, r_hi});
  endtask

  // Defaults out of reset: start reference 33, on/off, pot limits 1365/2375.
  task automatic test_reset_defaults();
    send_item(KIND_SAMPLE, 10'd131, 12'($urandom));
    send_item(KIND_SAMPLE, 10'd132, 12'($urandom));
    send_item(KIND_SAMPLE, 10'd1023, 12'($urandom));
    send_item(KIND_BUTTON, 10'($urandom), 12'd1365);
    send_item(KIND_BUTTON, 10'($urandom), 12'd1366);
    send_item(KIND_BUTTON, 10'($urandom), 12'd2376);
    send_item(KIND_BUTTON, 10'($urandom), 12'd2375);
    send_item(KIND_SAMPLE, 10'd0, 12'($urandom));
    send_item(KIND_BUTTON, 10'($urandom), 12'd4095);
    send_item(KIND_SAMPLE, 10'd182, 12'($urandom));
    send_item(KIND_SAMPLE, 10'd190, 12'($urandom));
  endtask

  // Zero reference grades any excess as large; widest top and limits.
  task automatic test_onoff_extremes();
    configure(MODE_ONOFF, 16'hFFFF, 12'd0, 12'hFFF, 8'd0, 8'd255, 8'd1);
    send_item(KIND_BUTTON, 10'($urandom), 12'd0);
    send_item(KIND_SAMPLE, 10'd0, 12'($urandom));
    send_item(KIND_SAMPLE, 10'd1, 12'($urandom));
    send_item(KIND_BUTTON, 10'($urandom), 12'hFFF);
    send_item(KIND_SAMPLE, 10'd1019, 12'($urandom));
  endtask

  // Full error drives the duty to top, zero error leaves a partial duty,
  // then hot samples pull the accumulator down, though it stays non-negative.
  task automatic test_pi_directed();
    configure(MODE_PI, 16'hFFFF, 12'd1365, 12'd2375, 8'd30, 8'd40, 8'd255);
    send_item(KIND_BUTTON, 10'($urandom), 12'hFFF);
    send_item(KIND_SAMPLE, 10'd0, 12'($urandom));
    send_item(KIND_SAMPLE, 10'd1020, 12'($urandom));
    send_item(KIND_SAMPLE, 10'd1023, 12'($urandom));
    send_item(KIND_SAMPLE, 10'd1023, 12'($urandom));
  endtask

  // Low limit above high limit: mid is never picked.
  task automatic test_crossed_limits();
    configure(MODE_PI, 16'd1, 12'd3000, 12'd1000, 8'd10, 8'd20, 8'd30);
    send_item(KIND_BUTTON, 10'($urandom), 12'd3001);
    send_item(KIND_BUTTON, 10'($urandom), 12'd1000);
    send_item(KIND_SAMPLE, 10'd0, 12'($urandom));
    send_item(KIND_BUTTON, 10'($urandom), 12'd3000);
    send_item(KIND_SAMPLE, 10'd1023, 12'($urandom));
  endtask

  // Closed-loop temperature walk: heat rises while the heater is on and falls
  // otherwise, with button presses, disturbances and stray samples mixed in.
  task automatic test_random_regulation();
    int          temp;
    int          roll;
    int          pot;
    logic [11:0] lo;
    logic [11:0] hi;
    logic [11:0] swap;
    logic [15:0] top;
    for (int phase = 0; phase < 12; phase++) begin
      lo = 12'($urandom);
      hi = 12'($urandom);
      if (lo > hi && $urandom_range(0, 4) != 0) begin
        swap = lo;
        lo   = hi;
        hi   = swap;
      end
      case ($urandom_range(0, 5))
        0:       top = 16'd1;
        1:       top = 16'hFFFF;
        2:       top = 16'd35999;
        default: top = 16'($urandom_range(1, 65535));
      endcase
      if ($urandom_range(0, 4) == 0)
        configure(1'($urandom), top, lo, hi, 8'($urandom), 8'($urandom), 8'($urandom));
      else
        configure(1'($urandom), top, lo, hi, 8'($urandom_range(20, 60)),
                  8'($urandom_range(20, 60)), 8'($urandom_range(20, 60)));
      burst_mode = (phase % 4 == 3);
      temp = 4 * int'(ref_deg_q);
      for (int n = 0; n < 150; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          case ($urandom_range(0, 2))
            0:       pot = int'(cfg_pot_lo) + int'($urandom_range(0, 2)) - 1;
            1:       pot = int'(cfg_pot_hi) + int'($urandom_range(0, 2)) - 1;
            default: pot = $urandom_range(0, 4095);
          endcase
          if (pot < 0) pot = 0;
          if (pot > 4095) pot = 4095;
          send_item(KIND_BUTTON, 10'($urandom), 12'(pot));
        end else if (roll < 16) begin
          send_item(KIND_SAMPLE, 10'($urandom), 12'($urandom));
        end else begin
          if (heater_q) temp += $urandom_range(0, 6);
          else temp -= $urandom_range(0, 6);
          if ($urandom_range(0, 19) == 0) temp += int'($urandom_range(0, 80)) - 40;
          if (temp < 0) temp = 0;
          if (temp > 1023) temp = 1023;
          send_item(KIND_SAMPLE, 10'(temp), 12'($urandom));
        end
      end
    end
    burst_mode = 1'b0;
  endtask

  // Result side: after each taken result, drop out_tready for a random gap from draw_gap.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_status.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          want_status = pending_status.pop_front();
          if (out_tdata[15:0] !== want_status.duty)
            report_mismatch("pwm_duty", out_tdata[15:0], want_status.duty);
          if (out_tdata[16] !== want_status.heater)
            report_mismatch("heater_on", out_tdata[16], want_status.heater);
          if (out_tdata[18:17] !== want_status.ref_led)
            report_mismatch("ref_led", out_tdata[18:17], want_status.ref_led);
          if (out_tdata[20:19] !== want_status.ov_led)
            report_mismatch("peak_grade", out_tdata[20:19], want_status.ov_led);
          if (out_tdata[30:21] !== want_status.peak)
            report_mismatch("overshoot_peak", out_tdata[30:21], want_status.peak);
          if (out_tdata[38:31] !== want_status.ref_deg)
            report_mismatch("reference", out_tdata[38:31], want_status.ref_deg);
        end
        out_gap = draw_gap();
      end else if (out_gap != 0) begin
        out_gap--;
      end
    end
    out_tready <= (out_gap == 0);
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = KIND_SAMPLE;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_MODE;
    cfg_wdata  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_onoff_extremes();
    test_pi_directed();
    test_crossed_limits();
    test_random_regulation();
    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
